// ===== hdl/blps_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blps_pkg
// Shared types and constants of the buzzer and LED pattern sequencer.
// ----------------------------------------------------------------------------
package blps_pkg;

	// buzz kinds
	localparam logic [1:0] KIND_NONE    = 2'd0;
	localparam logic [1:0] KIND_KEY     = 2'd1;
	localparam logic [1:0] KIND_CONFIRM = 2'd2;
	localparam logic [1:0] KIND_WARN    = 2'd3;

	// item function codes
	localparam logic FUNC_TICK    = 1'b0;
	localparam logic FUNC_REQUEST = 1'b1;

	// configuration register indexes
	localparam logic REG_NET_PATTERN    = 1'b0;
	localparam logic REG_FILTER_PATTERN = 1'b1;

	// network LED pattern codes
	localparam logic [2:0] NET_UNCONNECTED = 3'd0;
	localparam logic [2:0] NET_OFFLINE     = 3'd1;
	localparam logic [2:0] NET_ROUTER      = 3'd2;
	localparam logic [2:0] NET_CLOUD       = 3'd3;
	localparam logic [2:0] NET_CONFIG      = 3'd4;

	// filter LED pattern codes
	localparam logic [1:0] FLT_OFF   = 2'd0;
	localparam logic [1:0] FLT_BLINK = 2'd1;
	localparam logic [1:0] FLT_ON    = 2'd2;

	// buzzer schedule points
	localparam logic [5:0] KEY_END     = 6'd3;
	localparam logic [5:0] CONFIRM_END = 6'd20;
	localparam logic [5:0] WARN_END    = 6'd37;

	// LED schedule points
	localparam logic [7:0] NET_SLOW_OFF    = 8'd5;
	localparam logic [7:0] NET_SLOW_PERIOD = 8'd55;
	localparam logic [7:0] NET_RTR_OFF     = 8'd25;
	localparam logic [7:0] NET_RTR_PERIOD  = 8'd100;
	localparam logic [7:0] NET_FAST_OFF    = 8'd5;
	localparam logic [7:0] NET_FAST_PERIOD = 8'd10;
	localparam logic [5:0] FLT_OFF_AT      = 6'd25;
	localparam logic [5:0] FLT_PERIOD      = 6'd50;

	// one buzzer step request
	typedef struct packed {
		logic       tick;
		logic       request;
		logic [1:0] kind;
	} blps_buzz_step_t;

endpackage

// ===== hdl/blps_buzzer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blps_buzzer
// Buzzer request latch and per-kind on/off schedule, one schedule step per tick.
// ----------------------------------------------------------------------------
module blps_buzzer import blps_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  blps_buzz_step_t step,
	output logic            level_next
);

	logic [1:0] pending_q;
	logic [1:0] active_q;
	logic [5:0] count_q;
	logic       level_q;

	logic [1:0] pending_d;
	logic [1:0] active_d;
	logic [5:0] count_d;
	logic       level_d;
	logic [1:0] act;
	logic [5:0] c;
	logic       done;

	// schedule step
	always_comb begin
		pending_d = pending_q;
		active_d  = active_q;
		count_d   = count_q;
		level_d   = level_q;
		c         = count_q;
		done      = 1'b0;
		act       = (count_q == 6'd0) ? pending_q : active_q;
		if (step.request) begin
			pending_d = step.kind;
		end else if (step.tick) begin
			active_d = act;
			case (act)
				KIND_KEY: begin
					if (c == 6'd0) level_d = 1'b1;
					done = (c >= KEY_END);
				end
				KIND_CONFIRM: begin
					if (c == 6'd0) level_d = 1'b1;
					done = (c >= CONFIRM_END);
				end
				KIND_WARN: begin
					if (c == 6'd0 || c == 6'd8 || c == 6'd16 || c == 6'd24 || c == 6'd32)
						level_d = 1'b1;
					if (c == 6'd5 || c == 6'd13 || c == 6'd21 || c == 6'd29)
						level_d = 1'b0;
					done = (c >= WARN_END);
				end
				default: begin
					level_d = 1'b0;
				end
			endcase
			if (act != KIND_NONE) begin
				if (done) begin
					level_d   = 1'b0;
					count_d   = 6'd0;
					pending_d = KIND_NONE;
				end else begin
					count_d = c + 6'd1;
				end
			end
		end
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= KIND_NONE;
			active_q  <= KIND_NONE;
			count_q   <= '0;
			level_q   <= 1'b0;
		end else begin
			pending_q <= pending_d;
			active_q  <= active_d;
			count_q   <= count_d;
			level_q   <= level_d;
		end
	end

	assign level_next = level_d;

endmodule

// ===== hdl/blps_leds.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blps_leds
// Network and filter indicator LED blink patterns with their counters.
// ----------------------------------------------------------------------------
module blps_leds import blps_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       advance,
	input  logic [2:0] net_pattern,
	input  logic [1:0] filter_pattern,
	output logic       net_next,
	output logic       filter_next
);

	logic [7:0] net_cnt_q;
	logic [5:0] flt_cnt_q;
	logic       net_lvl_q;
	logic       flt_lvl_q;

	logic [7:0] net_cnt_d;
	logic [5:0] flt_cnt_d;
	logic       net_lvl_d;
	logic       flt_lvl_d;
	logic [7:0] net_inc;
	logic [5:0] flt_inc;
	logic [7:0] off_at;
	logic [7:0] period;

	assign net_inc = net_cnt_q + 8'd1;
	assign flt_inc = flt_cnt_q + 6'd1;

	// network LED step
	always_comb begin
		net_cnt_d = net_cnt_q;
		net_lvl_d = net_lvl_q;
		off_at    = NET_SLOW_OFF;
		period    = NET_SLOW_PERIOD;
		if (net_pattern == NET_ROUTER) begin
			off_at = NET_RTR_OFF;
			period = NET_RTR_PERIOD;
		end
		if (advance) begin
			case (net_pattern)
				NET_UNCONNECTED, NET_OFFLINE, NET_ROUTER: begin
					if (net_cnt_q == 8'd0) net_lvl_d = 1'b1;
					if (net_cnt_q == off_at) net_lvl_d = 1'b0;
					net_cnt_d = (net_inc == period) ? 8'd0 : net_inc;
				end
				NET_CLOUD: begin
					net_lvl_d = 1'b1;
				end
				NET_CONFIG: begin
					if (net_cnt_q == 8'd0) net_lvl_d = 1'b1;
					if (net_cnt_q == NET_FAST_OFF) net_lvl_d = 1'b0;
					net_cnt_d = (net_inc >= NET_FAST_PERIOD) ? 8'd0 : net_inc;
				end
				default: begin
					net_lvl_d = net_lvl_q;
				end
			endcase
		end
	end

	// filter LED step
	always_comb begin
		flt_cnt_d = flt_cnt_q;
		flt_lvl_d = flt_lvl_q;
		if (advance) begin
			case (filter_pattern)
				FLT_OFF: flt_lvl_d = 1'b0;
				FLT_BLINK: begin
					if (flt_cnt_q == 6'd0) flt_lvl_d = 1'b1;
					else if (flt_cnt_q == FLT_OFF_AT) flt_lvl_d = 1'b0;
					flt_cnt_d = (flt_inc >= FLT_PERIOD) ? 6'd0 : flt_inc;
				end
				FLT_ON: flt_lvl_d = 1'b1;
				default: flt_lvl_d = flt_lvl_q;
			endcase
		end
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			net_cnt_q <= '0;
			flt_cnt_q <= '0;
			net_lvl_q <= 1'b0;
			flt_lvl_q <= 1'b0;
		end else begin
			net_cnt_q <= net_cnt_d;
			flt_cnt_q <= flt_cnt_d;
			net_lvl_q <= net_lvl_d;
			flt_lvl_q <= flt_lvl_d;
		end
	end

	assign net_next    = net_lvl_d;
	assign filter_next = flt_lvl_d;

endmodule

// ===== hdl/buzzer_led_pattern_sequencer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// buzzer_led_pattern_sequencer_unit
// Tick-driven sequencer for a buzzer and two indicator LEDs.
// ----------------------------------------------------------------------------
// Each beat is a buzzer request or a timer tick and yields one beat of the
// three output levels as they stand after it. The block takes one beat per
// cycle while the receiver does not stall; a beat goes through an input
// register, the state update and a result register, in that order. The user
// must write pattern registers through cfg_we/cfg_index/cfg_data only while
// no beat is in flight; the block itself does not enforce this.
module buzzer_led_pattern_sequencer_unit import blps_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [2:0] cfg_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       func,
	input  logic [1:0] buzz_kind,
	input  logic       test_mode,
	input  logic       net_reset_busy,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       buzzer_on,
	output logic       net_led_on,
	output logic       filter_light
);

	logic [2:0] net_pattern_q;
	logic [1:0] filter_pattern_q;

	logic       valid_s1;
	logic       func_s1;
	logic [1:0] kind_s1;
	logic       frozen_s1;

	logic       out_valid_q;
	logic       buzzer_q;
	logic       net_q;
	logic       filter_q;

	logic            out_free;
	logic            advance;
	logic            in_take;
	blps_buzz_step_t buzz_step;
	logic            buzz_next;
	logic            net_next;
	logic            filter_next;

	// handshake
	assign out_free = !out_valid_q || !out_stall;
	assign advance  = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	assign in_take  = in_valid && !in_stall;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			net_pattern_q    <= NET_UNCONNECTED;
			filter_pattern_q <= FLT_OFF;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_NET_PATTERN:    net_pattern_q    <= cfg_data;
				REG_FILTER_PATTERN: filter_pattern_q <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			func_s1   <= func;
			kind_s1   <= buzz_kind;
			frozen_s1 <= test_mode | net_reset_busy;
		end
	end

	// step controls
	assign buzz_step.tick    = advance && (func_s1 == FUNC_TICK);
	assign buzz_step.request = advance && (func_s1 == FUNC_REQUEST);
	assign buzz_step.kind    = kind_s1;

	blps_buzzer u_buzzer (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (buzz_step),
		.level_next (buzz_next)
	);

	blps_leds u_leds (
		.clk            (clk),
		.arst_n         (arst_n),
		.advance        (buzz_step.tick && !frozen_s1),
		.net_pattern    (net_pattern_q),
		.filter_pattern (filter_pattern_q),
		.net_next       (net_next),
		.filter_next    (filter_next)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			buzzer_q <= buzz_next;
			net_q    <= net_next;
			filter_q <= filter_next;
		end
	end

	assign out_valid    = out_valid_q;
	assign buzzer_on    = buzzer_q;
	assign net_led_on   = net_q;
	assign filter_light = filter_q;

endmodule

// ===== tb/buzzer_led_pattern_sequencer_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// buzzer_led_pattern_sequencer_checker
// Watches the beat channels of the sequencer and checks every result beat.
// ----------------------------------------------------------------------------
// Tracks pattern register writes, runs its own copy of the buzzer and LED
// sequencing on each accepted input beat, and compares each accepted result
// beat against the oldest predicted set of output levels.
module buzzer_led_pattern_sequencer_checker import blps_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [2:0] cfg_data,
	input  logic       in_valid,
	input  logic       in_stall,
	input  logic       func,
	input  logic [1:0] buzz_kind,
	input  logic       test_mode,
	input  logic       net_reset_busy,
	input  logic       out_valid,
	input  logic       out_stall,
	input  logic       buzzer_on,
	input  logic       net_led_on,
	input  logic       filter_light,
	output int         mismatch_count,
	output int         levels_pending
);

	typedef struct packed {
		logic buzzer;
		logic net;
		logic filter;
	} led_levels_t;

	// predicted levels, oldest first
	led_levels_t levels_due_q[$];

	// pattern registers as written
	logic [2:0] net_pat;
	logic [1:0] flt_pat;

	// sequencer state
	logic [1:0] want_kind;
	logic [1:0] sound_kind;
	logic [5:0] sound_tick;
	logic [7:0] net_tick;
	logic [5:0] flt_tick;
	logic       buzz_lvl;
	logic       net_lvl;
	logic       flt_lvl;

	// slow and router blink share one shape
	task automatic net_blink(input logic [7:0] off_at, input logic [7:0] period);
		if (net_tick == 8'd0) net_lvl = 1'b1;
		if (net_tick == off_at) net_lvl = 1'b0;
		net_tick = net_tick + 8'd1;
		if (net_tick == period) net_tick = 8'd0;
	endtask

	// one input beat through the sequencer
	task automatic advance_levels(input logic f, input logic [1:0] kind, input logic frozen);
		logic [5:0] c;
		logic       done;
		if (f == FUNC_REQUEST) begin
			want_kind = kind;
		end else begin
			// buzzer schedule
			if (sound_kind != want_kind && sound_tick == 6'd0) sound_kind = want_kind;
			c = sound_tick;
			done = 1'b0;
			case (sound_kind)
				KIND_KEY: begin
					if (c == 6'd0) buzz_lvl = 1'b1;
					if (c >= KEY_END) done = 1'b1;
				end
				KIND_CONFIRM: begin
					if (c == 6'd0) buzz_lvl = 1'b1;
					if (c >= CONFIRM_END) done = 1'b1;
				end
				KIND_WARN: begin
					if (c == 6'd0 || c == 6'd8 || c == 6'd16 || c == 6'd24 || c == 6'd32)
						buzz_lvl = 1'b1;
					if (c == 6'd5 || c == 6'd13 || c == 6'd21 || c == 6'd29)
						buzz_lvl = 1'b0;
					if (c >= WARN_END) done = 1'b1;
				end
				default: begin
					buzz_lvl = 1'b0;
				end
			endcase
			if (sound_kind != KIND_NONE) begin
				if (done) begin
					buzz_lvl = 1'b0;
					sound_tick = 6'd0;
					want_kind = KIND_NONE;
				end else begin
					sound_tick = c + 6'd1;
				end
			end

			// led patterns, held while frozen
			if (!frozen) begin
				case (net_pat)
					NET_UNCONNECTED, NET_OFFLINE: net_blink(NET_SLOW_OFF, NET_SLOW_PERIOD);
					NET_ROUTER: net_blink(NET_RTR_OFF, NET_RTR_PERIOD);
					NET_CLOUD: net_lvl = 1'b1;
					NET_CONFIG: begin
						if (net_tick == 8'd0) net_lvl = 1'b1;
						if (net_tick == NET_FAST_OFF) net_lvl = 1'b0;
						net_tick = net_tick + 8'd1;
						if (net_tick >= NET_FAST_PERIOD) net_tick = 8'd0;
					end
					default: ;
				endcase
				case (flt_pat)
					FLT_OFF: flt_lvl = 1'b0;
					FLT_BLINK: begin
						if (flt_tick == 6'd0) flt_lvl = 1'b1;
						else if (flt_tick == FLT_OFF_AT) flt_lvl = 1'b0;
						flt_tick = flt_tick + 6'd1;
						if (flt_tick >= FLT_PERIOD) flt_tick = 6'd0;
					end
					FLT_ON: flt_lvl = 1'b1;
					default: ;
				endcase
			end
		end
		levels_due_q.push_back('{buzzer: buzz_lvl, net: net_lvl, filter: flt_lvl});
	endtask

	// watch both channels and the register port
	always @(posedge clk or negedge arst_n) begin
		led_levels_t exp_lv;
		if (!arst_n) begin
			net_pat = NET_UNCONNECTED;
			flt_pat = FLT_OFF;
			want_kind = KIND_NONE;
			sound_kind = KIND_NONE;
			sound_tick = '0;
			net_tick = '0;
			flt_tick = '0;
			buzz_lvl = 1'b0;
			net_lvl = 1'b0;
			flt_lvl = 1'b0;
			levels_due_q.delete();
			mismatch_count = 0;
			levels_pending = 0;
		end else begin
			// result beat against oldest prediction
			if (out_valid && !out_stall) begin
				if (levels_due_q.size() == 0) begin
					$error("result beat with no prediction waiting");
					mismatch_count++;
				end else begin
					exp_lv = levels_due_q.pop_front();
					if (buzzer_on !== exp_lv.buzzer) begin
						$error("buzzer_on mismatch: expected %0b, got %0b", exp_lv.buzzer, buzzer_on);
						mismatch_count++;
					end
					if (net_led_on !== exp_lv.net) begin
						$error("net_led_on mismatch: expected %0b, got %0b", exp_lv.net, net_led_on);
						mismatch_count++;
					end
					if (filter_light !== exp_lv.filter) begin
						$error("filter_light mismatch: expected %0b, got %0b",
							exp_lv.filter, filter_light);
						mismatch_count++;
					end
				end
			end

			// pattern register writes
			if (cfg_we) begin
				if (cfg_index == REG_NET_PATTERN) net_pat = cfg_data;
				else flt_pat = cfg_data[1:0];
			end

			// input beat
			if (in_valid && !in_stall)
				advance_levels(func, buzz_kind, test_mode | net_reset_busy);

			levels_pending = levels_due_q.size();
		end
	end

endmodule

// ===== tb/tb_buzzer_led_pattern_sequencer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_buzzer_led_pattern_sequencer_unit
// Testbench for the buzzer and LED pattern sequencer.
// ----------------------------------------------------------------------------
// Sends a directed run of requests, cancels, overlapping sounds and frozen
// ticks, then random beats across a series of network and filter pattern
// settings, including the unused codes. The sender works in bursts with
// gaps and the receiver stalls on its own pattern; the checker predicts and
// compares every result beat.
module tb_buzzer_led_pattern_sequencer_unit import blps_pkg::*; ();

	localparam int PHASE_BEATS = 140;
	localparam int NUM_PHASES  = 10;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_we = 1'b0;
	logic       cfg_index = 1'b0;
	logic [2:0] cfg_data = '0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic       func = FUNC_TICK;
	logic [1:0] buzz_kind = KIND_NONE;
	logic       test_mode = 1'b0;
	logic       net_reset_busy = 1'b0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic       buzzer_on;
	logic       net_led_on;
	logic       filter_light;

	int         mismatch_count;
	int         levels_pending;
	logic       in_taken = 1'b0;
	int         burst_left = 0;

	// pattern settings per phase: router then slow blink to exercise the wrap
	logic [2:0] net_plan [NUM_PHASES] = '{NET_ROUTER, NET_OFFLINE, NET_CONFIG, 3'd7,
		NET_UNCONNECTED, NET_CLOUD, 3'd5, 3'd6, NET_ROUTER, NET_UNCONNECTED};
	logic [1:0] flt_plan [NUM_PHASES] = '{FLT_BLINK, FLT_OFF, FLT_ON, 2'd3,
		FLT_BLINK, FLT_ON, FLT_BLINK, FLT_OFF, FLT_ON, 2'd3};

	buzzer_led_pattern_sequencer_unit u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.func          (func),
		.buzz_kind     (buzz_kind),
		.test_mode     (test_mode),
		.net_reset_busy(net_reset_busy),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.buzzer_on     (buzzer_on),
		.net_led_on    (net_led_on),
		.filter_light  (filter_light)
	);

	buzzer_led_pattern_sequencer_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.func          (func),
		.buzz_kind     (buzz_kind),
		.test_mode     (test_mode),
		.net_reset_busy(net_reset_busy),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.buzzer_on     (buzzer_on),
		.net_led_on    (net_led_on),
		.filter_light  (filter_light),
		.mismatch_count(mismatch_count),
		.levels_pending(levels_pending)
	);

	// clock
	initial begin
		forever #1 clk = ~clk;
	end

	// run limit
	initial begin
		#1000000;
		$display("FAIL");
		$finish;
	end

	// input acceptance seen at the rising edge, used at the next falling edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) in_taken <= 1'b0;
		else in_taken <= in_valid & ~in_stall;
	end

	// receiver stall pattern: free, random, heavy or alternating stretches
	int stall_mode = 0;
	int stall_left = 0;
	int stall_phase = 0;
	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_left = $urandom_range(10, 80);
		end
		stall_left--;
		stall_phase++;
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= 1'($urandom_range(0, 1));
			2: out_stall <= ($urandom_range(0, 7) != 0);
			default: out_stall <= stall_phase[1];
		endcase
	end

	// one input beat, in bursts with random gaps
	task automatic feed(input logic f, input logic [1:0] kind, input logic tm, input logic nrb);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		in_valid <= 1'b1;
		func <= f;
		buzz_kind <= kind;
		test_mode <= tm;
		net_reset_busy <= nrb;
		do @(negedge clk); while (!in_taken);
		burst_left--;
	endtask

	// stop sending and wait until every result has come back
	task automatic drain;
		in_valid <= 1'b0;
		burst_left = 0;
		@(negedge clk);
		while (levels_pending != 0) @(negedge clk);
	endtask

	// write both pattern registers, block idle
	task automatic set_patterns(input logic [2:0] net_p, input logic [1:0] flt_p);
		cfg_we <= 1'b1;
		cfg_index <= REG_NET_PATTERN;
		cfg_data <= net_p;
		@(negedge clk);
		cfg_index <= REG_FILTER_PATTERN;
		cfg_data <= {1'($urandom_range(0, 1)), flt_p};
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// random beat: mostly ticks so sounds play out, with requests mixed in
	task automatic feed_random;
		logic f;
		f = ($urandom_range(0, 99) < 15) ? FUNC_REQUEST : FUNC_TICK;
		feed(f, 2'($urandom_range(0, 3)), ($urandom_range(0, 9) == 0),
			($urandom_range(0, 9) == 0));
	endtask

	initial begin
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: key sound, cancel, overlap, frozen ticks
		feed(FUNC_TICK, KIND_NONE, 1'b0, 1'b0);
		feed(FUNC_REQUEST, KIND_KEY, 1'b0, 1'b0);
		repeat (5) feed(FUNC_TICK, KIND_NONE, 1'b0, 1'b0);
		feed(FUNC_REQUEST, KIND_WARN, 1'b0, 1'b0);
		feed(FUNC_REQUEST, KIND_NONE, 1'b0, 1'b0);
		feed(FUNC_TICK, KIND_WARN, 1'b0, 1'b0);
		feed(FUNC_REQUEST, KIND_CONFIRM, 1'b1, 1'b1);
		feed(FUNC_TICK, KIND_NONE, 1'b1, 1'b0);
		feed(FUNC_TICK, KIND_NONE, 1'b0, 1'b1);
		feed(FUNC_REQUEST, KIND_WARN, 1'b0, 1'b0);
		repeat (4) feed(FUNC_TICK, KIND_KEY, 1'b1, 1'b1);
		repeat (6) feed(FUNC_TICK, KIND_CONFIRM, 1'b0, 1'b0);
		drain();

		// random phases across pattern settings
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			set_patterns(net_plan[ph], flt_plan[ph]);
			// warn sounds only finish after long runs of ticks
			if (ph % 3 == 0) begin
				feed(FUNC_REQUEST, KIND_WARN, 1'b0, 1'b0);
				repeat (40) feed(FUNC_TICK, KIND_NONE, 1'($urandom_range(0, 1)), 1'b0);
			end
			repeat (PHASE_BEATS) feed_random();
			drain();
		end

		repeat (10) @(negedge clk);
		if (mismatch_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
